### sv/b64sd_pkg.sv
`default_nettype none

package b64sd_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] NUL_CHAR = 8'h00;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic       error;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### sv/b64sd_core.sv
`default_nettype none

module b64sd_core
    import b64sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_result         o_res0,
    output t_result         o_res1,
    output logic [1:0]      o_count
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_partial, n_partial;
    logic       r_pad_pending, n_pad_pending;
    logic       r_error_seen, n_error_seen;
    logic       r_stopped, n_stopped;

    t_sextet    sx;
    logic       emit;
    logic [7:0] data_byte;
    logic       end_error;
    t_result    data_res;
    t_result    end_res;

    always_comb begin
        sx            = sextet_of(i_byte);
        emit          = 1'b0;
        data_byte     = 8'd0;
        n_phase       = r_phase;
        n_partial     = r_partial;
        n_pad_pending = r_pad_pending;
        n_error_seen  = r_error_seen;
        n_stopped     = r_stopped;

        if (!r_stopped) begin
            priority if (r_pad_pending && i_byte != PAD_CHAR) begin
                n_error_seen  = 1'b1;
                n_stopped     = 1'b1;
                n_pad_pending = 1'b0;
            end else if (i_byte == NUL_CHAR) begin
                n_stopped = 1'b1;
            end else if (i_byte == PAD_CHAR) begin
                n_pad_pending = (r_phase == 2'd1);
            end else if (sx.valid) begin
                n_phase = r_phase + 2'd1;
                unique case (r_phase)
                    2'd0: begin
                        n_partial = {sx.value, 2'b00};
                    end
                    2'd1: begin
                        emit      = 1'b1;
                        data_byte = r_partial | {6'd0, sx.value[5:4]};
                        n_partial = {sx.value[3:0], 4'd0};
                    end
                    2'd2: begin
                        emit      = 1'b1;
                        data_byte = r_partial | {4'd0, sx.value[5:2]};
                        n_partial = {sx.value[1:0], 6'd0};
                    end
                    default: begin
                        emit      = 1'b1;
                        data_byte = r_partial | {2'd0, sx.value};
                        n_partial = 8'd0;
                    end
                endcase
            end else begin
                n_phase = r_phase;
            end
        end

        end_error = n_error_seen | n_pad_pending;

        if (i_last) begin
            n_phase       = 2'd0;
            n_partial     = 8'd0;
            n_pad_pending = 1'b0;
            n_error_seen  = 1'b0;
            n_stopped     = 1'b0;
        end

        data_res = '{out_byte: data_byte, is_end: 1'b0, error: 1'b0};
        end_res  = '{out_byte: 8'd0, is_end: 1'b1, error: end_error};
        o_res0   = emit ? data_res : end_res;
        o_res1   = end_res;
        o_count  = {1'b0, emit} + {1'b0, i_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= 2'd0;
            r_partial     <= 8'd0;
            r_pad_pending <= 1'b0;
            r_error_seen  <= 1'b0;
            r_stopped     <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_partial     <= n_partial;
            r_pad_pending <= n_pad_pending;
            r_error_seen  <= n_error_seen;
            r_stopped     <= n_stopped;
        end
    end

endmodule

`default_nettype wire

### sv/base64_stream_decoder_unit.sv
`default_nettype none

// Streaming base64 decoder that takes one character per transaction and returns
// decoded bytes, plus one end transaction carrying the error flag after the character
// marked last. A character is registered on acceptance, decoded once the four-entry
// output queue has room and written into that queue, so a result passes the input
// register and the queue before it appears. One character is accepted every cycle while
// the queue has room; the output port drains one result per cycle while i_out_ready is
// high, so a last character that also completes a byte adds one extra result, and input
// is held back only when the queue cannot take two more results.

module base64_stream_decoder_unit
    import b64sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_is_end,
    output logic            o_error
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    t_result    r_queue [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;

    logic       pop;
    logic       fire;
    logic [2:0] kept;
    t_result    res0;
    t_result    res1;
    logic [1:0] push_count;
    t_result    head;

    b64sd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (push_count)
    );

    always_comb begin
        pop        = (r_count != 3'd0) && i_out_ready;
        kept       = r_count - {2'd0, pop};
        fire       = r_in_valid && (kept <= 3'd2);
        o_in_ready = !r_in_valid || fire;
        n_rd_ptr   = r_rd_ptr + {1'b0, pop};
        n_wr_ptr   = fire ? r_wr_ptr + push_count : r_wr_ptr;
        n_count    = kept + (fire ? {1'b0, push_count} : 3'd0);
        head       = r_queue[r_rd_ptr];
        o_out_valid = (r_count != 3'd0);
        o_out_byte  = head.out_byte;
        o_is_end    = head.is_end;
        o_error     = head.error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wr_ptr   <= 2'd0;
            r_rd_ptr   <= 2'd0;
            r_count    <= 3'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last;
        end
        if (fire && push_count != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (fire && push_count == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= res1;
        end
    end

endmodule

`default_nettype wire
